// ===== src/mdam_pkg.sv =====
// ----------------------------------------------------------------------------
// mdam_pkg
// Shared constants and controller/datapath interface types for the merger.
// ----------------------------------------------------------------------------
`default_nettype none

package mdam_pkg;

  localparam int DEV_SLOTS  = 4;
  localparam int AXIS_SLOTS = 16;
  localparam int DEV_W      = 2;
  localparam int AX_W       = 4;
  localparam int TBL        = DEV_SLOTS * AXIS_SLOTS;
  localparam int IDX_W      = DEV_W + AX_W;
  localparam int QBITS      = 7;

  localparam logic [1:0] MODE_DECLARE    = 2'd0;
  localparam logic [1:0] MODE_UPDATE     = 2'd1;
  localparam logic [1:0] MODE_DISCONNECT = 2'd2;
  localparam logic [1:0] MODE_QUERY      = 2'd3;

  localparam logic [1:0] MERGE_SUM   = 2'd0;
  localparam logic [1:0] MERGE_FIRST = 2'd1;
  localparam logic [1:0] MERGE_LAST  = 2'd2;

  typedef struct packed {
    logic take;
    logic rd;
    logic diff;
    logic mul;
    logic chk;
    logic div_step;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic last_dev;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/mdam_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdam_ctrl
// Sequencer for the merger: walks the device slots of a query, one scaling
// and division pass per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module mdam_ctrl import mdam_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t st,
  output cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_DIFF = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_CHK  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_ACC  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (st.is_query) state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = st.last_dev ? S_OUT : S_READ;
      end
      S_OUT: begin
        // hold until the output register is free
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/mdam_dp.sv =====
// ----------------------------------------------------------------------------
// mdam_dp
// Axis tables, scaling arithmetic, shared restoring divider, merge and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mdam_dp import mdam_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   st,
  input  wire logic [1:0]         mode,
  input  wire logic [DEV_W-1:0]   device,
  input  wire logic [AX_W-1:0]    axis,
  input  wire logic signed [31:0] raw_value,
  input  wire logic signed [31:0] range_min,
  input  wire logic signed [31:0] range_max,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [7:0]       merged_value
);

  logic [1:0]           strategy;
  logic [DEV_SLOTS-1:0] active;
  logic [TBL-1:0]       present;
  logic [TBL-1:0]       raw_ok;

  logic [31:0] lo_mem  [TBL];
  logic [31:0] hi_mem  [TBL];
  logic [31:0] raw_mem [TBL];

  logic [IDX_W-1:0] widx, ridx;
  logic [AX_W-1:0]  axis_q;
  logic [DEV_W-1:0] dev_cnt;

  logic signed [31:0] lo_rd, hi_rd, raw_rd;
  logic               use_q, rawok_q;

  logic signed [32:0] diff, span;
  logic               deg;
  logic signed [7:0]  raw_cl;
  logic signed [41:0] num;
  logic               neg, big;
  logic [41:0]        rem, dsh;
  logic [QBITS-1:0]   quo;
  logic [2:0]         div_cnt;

  logic signed [9:0]  sum;
  logic signed [7:0]  first, last;
  logic               any;

  logic signed [31:0] raw_s;
  logic signed [41:0] diff_x, span_x, mag;
  logic signed [7:0]  v, qs;
  logic signed [9:0]  sum_n;
  logic signed [7:0]  res;
  logic               do_upd;

  assign widx = {device, axis};
  assign ridx = {dev_cnt, axis_q};
  assign do_upd = active[device] && present[widx];

  assign st.is_query = (mode == MODE_QUERY);
  assign st.last_dev = (dev_cnt == DEV_W'(DEV_SLOTS - 1));
  assign st.div_last = (div_cnt == 3'd0);
  assign st.out_free = !out_valid || !out_stall;

  // table memories
  always_ff @(posedge clk) begin
    if (cmd.take && mode == MODE_DECLARE) begin
      lo_mem[widx] <= range_min;
      hi_mem[widx] <= range_max;
    end
    if (cmd.take && mode == MODE_UPDATE && do_upd) begin
      raw_mem[widx] <= raw_value;
    end
    if (cmd.rd) begin
      lo_rd  <= lo_mem[ridx];
      hi_rd  <= hi_mem[ridx];
      raw_rd <= raw_mem[ridx];
    end
  end

  // merge strategy, device-active and presence flags
  always_ff @(posedge clk) begin
    if (rst) begin
      strategy <= MERGE_SUM;
      active   <= '0;
      present  <= '0;
      raw_ok   <= '0;
    end else begin
      if (cfg_we) strategy <= cfg_data;
      if (cmd.take) begin
        case (mode)
          MODE_DECLARE: begin
            active[device] <= 1'b1;
            present[widx]  <= 1'b1;
          end
          MODE_UPDATE: begin
            if (do_upd) raw_ok[widx] <= 1'b1;
          end
          MODE_DISCONNECT: begin
            active[device] <= 1'b0;
            for (int a = 0; a < AXIS_SLOTS; a++) begin
              present[{device, AX_W'(a)}] <= 1'b0;
              raw_ok[{device, AX_W'(a)}]  <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    raw_s  = rawok_q ? raw_rd : 32'sd0;
    diff_x = {{9{diff[32]}}, diff};
    span_x = {{9{span[32]}}, span};
    mag    = num[41] ? -num : num;
    qs     = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (deg)      v = raw_cl;
    else if (big) v = neg ? -8'sd127 : 8'sd127;
    else          v = qs;
    sum_n = sum + {{2{v[7]}}, v};
    case (strategy)
      MERGE_SUM: begin
        if (sum > 10'sd127)       res = 8'sd127;
        else if (sum < -10'sd127) res = -8'sd127;
        else                      res = sum[7:0];
      end
      MERGE_FIRST: res = first;
      MERGE_LAST:  res = last;
      default:     res = 8'sd0;
    endcase
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      axis_q  <= axis;
      dev_cnt <= '0;
      sum     <= '0;
      first   <= '0;
      last    <= '0;
      any     <= 1'b0;
    end
    if (cmd.rd) begin
      use_q   <= active[dev_cnt] && present[ridx];
      rawok_q <= raw_ok[ridx];
    end
    if (cmd.diff) begin
      diff <= 33'(raw_s) - 33'(lo_rd);
      span <= 33'(hi_rd) - 33'(lo_rd);
      deg  <= (33'(hi_rd) - 33'(lo_rd)) <= 33'sd0;
      if (raw_s > 32'sd127)       raw_cl <= 8'sd127;
      else if (raw_s < -32'sd127) raw_cl <= -8'sd127;
      else                        raw_cl <= raw_s[7:0];
    end
    if (cmd.mul) begin
      num <= (diff_x <<< 8) - (diff_x <<< 1) - ((span_x <<< 7) - span_x);
    end
    if (cmd.chk) begin
      neg     <= num[41];
      big     <= mag >= (span_x <<< 7);
      rem     <= mag;
      dsh     <= span_x <<< (QBITS - 1);
      quo     <= '0;
      div_cnt <= 3'(QBITS - 1);
    end
    if (cmd.div_step) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[QBITS-2:0], 1'b1};
      end else begin
        quo <= {quo[QBITS-2:0], 1'b0};
      end
      dsh     <= dsh >> 1;
      div_cnt <= div_cnt - 3'd1;
    end
    if (cmd.acc) begin
      if (use_q) begin
        sum <= sum_n;
        if (!any) first <= v;
        any <= 1'b1;
        if (v != 8'sd0) last <= v;
      end
      dev_cnt <= dev_cnt + DEV_W'(1);
    end
    if (cmd.emit) merged_value <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/multi_device_axis_merger.sv =====
// ----------------------------------------------------------------------------
// multi_device_axis_merger
// Per-device absolute axis table with normalised, merged axis queries.
// ----------------------------------------------------------------------------
// Declare, update and disconnect beats are each taken in the idle state. A
// query walks the four device slots in turn through one shared restoring
// divider, each slot by read, difference, scale, check, 7 divide steps and
// accumulate, and it holds the input after it is accepted until the walk is
// done and the output register is loaded. The output register lets the next
// beat enter while a query result waits; a second query then holds at its end
// until the first result is taken. The user must write merge_strategy only
// while the block is idle; the block itself does not enforce it.
`default_nettype none

module multi_device_axis_merger import mdam_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic [1:0]         device,
  input  wire logic [3:0]         axis,
  input  wire logic signed [31:0] raw_value,
  input  wire logic signed [31:0] range_min,
  input  wire logic signed [31:0] range_max,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         merge_strategy,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [7:0]       merged_value
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  mdam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mdam_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .mode         (mode),
    .device       (device),
    .axis         (axis),
    .raw_value    (raw_value),
    .range_min    (range_min),
    .range_max    (range_max),
    .cfg_we       (cfg_valid),
    .cfg_data     (merge_strategy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .merged_value (merged_value)
  );

endmodule

`default_nettype wire
